// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Simulation builds get the checks;
// synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);
`define ASSERT_NEVER(label, clk_sig, rst_n_sig, expr, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg)
`define ASSERT_NEVER(label, clk_sig, rst_n_sig, expr, msg)
`endif
`endif

// ===== hdl/apsp_pkg.sv =====
`timescale 1ns / 1ps

package apsp_pkg;

  localparam int NODE_W = 6;
  localparam int COST_W = 16;
  localparam int DIST_W = 22;
  localparam int CFG_W  = 7;
  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [NODE_W-1:0]  src_node;
    logic [NODE_W-1:0]  dst_node;
    logic [COST_W-1:0]  link_distance;
    logic               link_present;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0]  path_distance;
    logic               reachable;
    logic               via_valid;
    logic [NODE_W-1:0]  via_node;
  } out_word_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_item;
    logic sweep_clr;
    logic sweep_inc;
    logic clear_wr;
    logic init_rd;
    logic link_wr_a;
    logic link_wr_b;
    logic take_n;
    logic loop_clr;
    logic row_rd;
    logic row_chk;
    logic sweep_j;
    logic next_i;
    logic set_done;
    logic rd_issue;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic sweep_last;
    logic j_last;
    logic i_last;
    logic k_last;
    logic n_zero;
    logic ik_reach;
    logic load_ok;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/apsp_ram.sv =====
`timescale 1ns / 1ps

module apsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/apsp_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module apsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  apsp_pkg::op_t     in_op,
  output apsp_pkg::dp_cmd_t cmd,
  input  apsp_pkg::dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD_A,
    S_LOAD_B,
    S_INIT,
    S_INIT_END,
    S_ROW,
    S_ROW_CHK,
    S_SWEEP,
    S_DONE,
    S_READ,
    S_READ_DATA
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;
  logic   accept;

  assign accept   = in_valid && !in_stall_r;
  assign in_stall = in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr  = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          unique case (in_op)
            apsp_pkg::OP_CLEAR: begin
              cmd.sweep_clr = 1'b1;
              state_nxt     = S_CLEAR;
            end
            apsp_pkg::OP_LOAD: begin
              state_nxt = S_LOAD_A;
            end
            apsp_pkg::OP_COMPUTE: begin
              cmd.sweep_clr = 1'b1;
              cmd.take_n    = 1'b1;
              state_nxt     = S_INIT;
            end
            apsp_pkg::OP_READ: begin
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LOAD_A: begin
        cmd.link_wr_a = sts.load_ok;
        state_nxt     = S_LOAD_B;
      end
      S_LOAD_B: begin
        cmd.link_wr_b = sts.load_ok;
        state_nxt     = S_IDLE;
      end
      S_INIT: begin
        cmd.init_rd   = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_INIT_END;
        end
      end
      S_INIT_END: begin
        // The last table write lands in this cycle.
        cmd.loop_clr = 1'b1;
        state_nxt    = sts.n_zero ? S_DONE : S_ROW;
      end
      S_ROW: begin
        cmd.row_rd = 1'b1;
        state_nxt  = S_ROW_CHK;
      end
      S_ROW_CHK: begin
        cmd.row_chk = 1'b1;
        if (sts.ik_reach) begin
          state_nxt = S_SWEEP;
        end else if (sts.i_last && sts.k_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.next_i = 1'b1;
          state_nxt  = S_ROW;
        end
      end
      S_SWEEP: begin
        cmd.sweep_j = 1'b1;
        if (sts.j_last) begin
          if (sts.i_last && sts.k_last) begin
            state_nxt = S_DONE;
          end else begin
            cmd.next_i = 1'b1;
            state_nxt  = S_ROW;
          end
        end
      end
      S_DONE: begin
        cmd.set_done = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_READ_DATA;
      end
      S_READ_DATA: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  `ASSERT_CLK(a_dist_port_a_excl, clk, rst_n, $onehot0({cmd.row_rd, cmd.sweep_j, cmd.rd_issue}), "distance port A driven by two users")
  `ASSERT_CLK(a_link_port_excl, clk, rst_n, $onehot0({cmd.clear_wr, cmd.init_rd, cmd.link_wr_a, cmd.link_wr_b}), "link store used twice in one cycle")
  `ASSERT_CLK(a_busy_stalls, clk, rst_n, (state_r != S_IDLE) |-> in_stall_r, "input taken while busy")

endmodule

// ===== hdl/apsp_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module apsp_dp #(
  parameter int MAX_NODES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  apsp_pkg::in_word_t            in_word,
  input  logic                          cfg_wr_en,
  input  logic [apsp_pkg::CFG_W-1:0]    cfg_wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output apsp_pkg::out_word_t           out_word,
  input  apsp_pkg::dp_cmd_t             cmd,
  output apsp_pkg::dp_sts_t             sts
);

  localparam int IdxW  = $clog2(MAX_NODES);
  localparam int CntW  = $clog2(MAX_NODES + 1);
  localparam int CellW = 2 * IdxW;
  localparam int Cells = 1 << CellW;
  localparam int DistW = apsp_pkg::DIST_W;
  localparam int CostW = apsp_pkg::COST_W;
  localparam int NodeW = apsp_pkg::NODE_W;
  localparam int LinkW = CostW + 1;
  localparam int DwW   = DistW + 1;
  localparam int ViaW  = IdxW + 1;

  logic [apsp_pkg::CFG_W-1:0] node_count_r;
  apsp_pkg::in_word_t         item_r;
  logic [CellW-1:0]           cell_r;
  logic [CntW-1:0]            n_r;
  logic [CntW-1:0]            n_eff;
  logic [CntW-1:0]            n_m1;
  logic [IdxW-1:0]            k_r, i_r, j_r;
  logic [DistW-1:0]           dik_r;
  logic                       ip_r;
  logic [CellW-1:0]           ip_cell_r;
  logic                       p_r;
  logic [CellW-1:0]           p_cell_r;
  logic [IdxW-1:0]            p_k_r;
  logic                       computed_r;
  logic                       out_valid_r;
  apsp_pkg::out_word_t        out_word_r;

  logic [IdxW-1:0]  s_idx, d_idx;
  logic             in_range;

  // Link store.
  logic             link_we;
  logic [CellW-1:0] link_waddr;
  logic [LinkW-1:0] link_wdata;
  logic [LinkW-1:0] link_rd;

  // Distance store (two copies for two reads a cycle) and via store.
  logic             dist_we;
  logic [CellW-1:0] dist_waddr;
  logic [DwW-1:0]   dist_wdata;
  logic [ViaW-1:0]  via_wdata;
  logic             dista_re;
  logic [CellW-1:0] dista_raddr;
  logic [DwW-1:0]   dista_rd;
  logic [DwW-1:0]   distb_rd;
  logic [ViaW-1:0]  via_rd;

  // Table build.
  logic [IdxW-1:0]  ini_i, ini_j;
  logic             ini_active;
  logic [DwW-1:0]   init_dist;
  logic [ViaW-1:0]  init_via;

  // Relaxation.
  logic [DistW:0]   sum;
  logic [DistW-1:0] s_sat;
  logic             relax_we;
  logic             show;

  assign s_idx    = IdxW'(item_r.src_node);
  assign d_idx    = IdxW'(item_r.dst_node);
  assign in_range = (32'(item_r.src_node) < MAX_NODES) && (32'(item_r.dst_node) < MAX_NODES);

  assign n_eff = (32'(node_count_r) > MAX_NODES) ? CntW'(MAX_NODES) : CntW'(node_count_r);
  assign n_m1  = n_r - CntW'(1);

  always_comb begin
    link_we    = cmd.clear_wr || cmd.link_wr_a || cmd.link_wr_b;
    link_waddr = cell_r;
    link_wdata = '0;
    if (cmd.link_wr_a) begin
      link_waddr = {s_idx, d_idx};
    end else if (cmd.link_wr_b) begin
      link_waddr = {d_idx, s_idx};
    end
    if (!cmd.clear_wr && item_r.link_present) begin
      link_wdata = {1'b1, item_r.link_distance};
    end
  end

  apsp_ram #(.Width(LinkW), .Depth(Cells)) u_link (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (cmd.init_rd),
    .rd_addr (cell_r),
    .rd_data (link_rd)
  );

  // Initial table entry for the cell whose link was read in the previous cycle.
  assign ini_i      = ip_cell_r[CellW-1:IdxW];
  assign ini_j      = ip_cell_r[IdxW-1:0];
  assign ini_active = (CntW'(ini_i) < n_r) && (CntW'(ini_j) < n_r);

  always_comb begin
    init_dist = '0;
    init_via  = '0;
    if (ini_active) begin
      if (ini_i == ini_j) begin
        init_dist = {1'b1, {DistW{1'b0}}};
      end else if (link_rd[CostW]) begin
        init_dist = {1'b1, DistW'(link_rd[CostW-1:0])};
        init_via  = {1'b1, ini_i};
      end
    end
  end

  // One relaxation per cycle while a row is swept: d[i][j] against d[i][k] + d[k][j].
  assign sum      = {1'b0, dik_r} + {1'b0, dista_rd[DistW-1:0]};
  assign s_sat    = sum[DistW] ? {DistW{1'b1}} : sum[DistW-1:0];
  assign relax_we = p_r && dista_rd[DistW] &&
                    (!distb_rd[DistW] || (distb_rd[DistW-1:0] > s_sat));

  assign dist_we    = ip_r || relax_we;
  assign dist_waddr = ip_r ? ip_cell_r : p_cell_r;
  assign dist_wdata = ip_r ? init_dist : {1'b1, s_sat};
  assign via_wdata  = ip_r ? init_via : {1'b1, p_k_r};

  assign dista_re = cmd.row_rd || cmd.sweep_j || cmd.rd_issue;
  always_comb begin
    if (cmd.row_rd) begin
      dista_raddr = {i_r, k_r};
    end else if (cmd.sweep_j) begin
      dista_raddr = {k_r, j_r};
    end else begin
      dista_raddr = {s_idx, d_idx};
    end
  end

  apsp_ram #(.Width(DwW), .Depth(Cells)) u_dist_a (
    .clk     (clk),
    .wr_en   (dist_we),
    .wr_addr (dist_waddr),
    .wr_data (dist_wdata),
    .rd_en   (dista_re),
    .rd_addr (dista_raddr),
    .rd_data (dista_rd)
  );

  apsp_ram #(.Width(DwW), .Depth(Cells)) u_dist_b (
    .clk     (clk),
    .wr_en   (dist_we),
    .wr_addr (dist_waddr),
    .wr_data (dist_wdata),
    .rd_en   (cmd.sweep_j),
    .rd_addr ({i_r, j_r}),
    .rd_data (distb_rd)
  );

  apsp_ram #(.Width(ViaW), .Depth(Cells)) u_via (
    .clk     (clk),
    .wr_en   (dist_we),
    .wr_addr (dist_waddr),
    .wr_data (via_wdata),
    .rd_en   (cmd.rd_issue),
    .rd_addr ({s_idx, d_idx}),
    .rd_data (via_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= apsp_pkg::NODE_COUNT_RESET;
      cell_r       <= '0;
      k_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
      ip_r         <= 1'b0;
      p_r          <= 1'b0;
      computed_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end

      if (cmd.sweep_clr) begin
        cell_r <= '0;
      end else if (cmd.sweep_inc) begin
        cell_r <= cell_r + CellW'(1);
      end

      if (cmd.loop_clr) begin
        k_r <= '0;
        i_r <= '0;
        j_r <= '0;
      end else if (cmd.next_i) begin
        j_r <= '0;
        if (sts.i_last) begin
          i_r <= '0;
          k_r <= k_r + IdxW'(1);
        end else begin
          i_r <= i_r + IdxW'(1);
        end
      end else if (cmd.sweep_j) begin
        j_r <= j_r + IdxW'(1);
      end

      ip_r <= cmd.init_rd;
      p_r  <= cmd.sweep_j;

      if (cmd.take_n) begin
        computed_r <= 1'b0;
      end else if (cmd.set_done) begin
        computed_r <= 1'b1;
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign show = in_range && computed_r;

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_word;
    end
    if (cmd.take_n) begin
      n_r <= n_eff;
    end
    if (cmd.row_chk) begin
      dik_r <= dista_rd[DistW-1:0];
    end
    ip_cell_r <= cell_r;
    p_cell_r  <= {i_r, j_r};
    p_k_r     <= k_r;
    if (cmd.out_load) begin
      out_word_r.path_distance <= (show && dista_rd[DistW]) ? dista_rd[DistW-1:0] : '0;
      out_word_r.reachable     <= show && dista_rd[DistW];
      out_word_r.via_valid     <= show && via_rd[IdxW];
      out_word_r.via_node      <= (show && via_rd[IdxW]) ? NodeW'(via_rd[IdxW-1:0]) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign sts.sweep_last = &cell_r;
  assign sts.j_last     = (CntW'(j_r) == n_m1);
  assign sts.i_last     = (CntW'(i_r) == n_m1);
  assign sts.k_last     = (CntW'(k_r) == n_m1);
  assign sts.n_zero     = (n_r == '0);
  assign sts.ik_reach   = dista_rd[DistW];
  assign sts.load_ok    = in_range && (item_r.src_node != item_r.dst_node);
  assign sts.out_free   = !out_valid_r || !out_stall;

  `ASSERT_NEVER(a_write_port_excl, clk, rst_n, ip_r && p_r, "table build and relaxation write together")
  `ASSERT_CLK(a_out_slot_free, clk, rst_n, cmd.out_load |-> (!out_valid_r || !out_stall), "result word overwritten")
  `ASSERT_CLK(a_no_diag_relax, clk, rst_n, relax_we |-> (p_cell_r[CellW-1:IdxW] != p_cell_r[IdxW-1:0]), "diagonal distance relaxed")

endmodule

// ===== hdl/all_pairs_shortest_path.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall  apsp_pkg::in_word_t (operation, nodes, link)
// out_     output     out_valid/out_stall apsp_pkg::out_word_t (distance, via)
// cfg_     input      cfg_wr_en          cfg_wr_data = node_count
//
// Per word: a load writes the link both ways, a read waits for a free output
// register, a clear sweeps all C link cells, where C is the cell count (next
// power of two of MAX_NODES, squared), and a compute rebuilds the table over
// all C cells, then runs the single relaxation unit over the n active nodes,
// one distance update per cycle while it sweeps a row. After reset the link
// store is swept clear, all C cells, with in_stall high. A read result sits in
// the output register while out_stall holds; the next word can be taken meanwhile.

module all_pairs_shortest_path #(
  parameter int MAX_NODES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  apsp_pkg::in_word_t         in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output apsp_pkg::out_word_t        out_word,
  input  logic                       cfg_wr_en,
  input  logic [apsp_pkg::CFG_W-1:0] cfg_wr_data
);

  apsp_pkg::dp_cmd_t cmd;
  apsp_pkg::dp_sts_t sts;

  apsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_word.operation),
    .cmd      (cmd),
    .sts      (sts)
  );

  apsp_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== dv/all_pairs_shortest_path_tb.sv =====
`timescale 1ns / 1ps

module all_pairs_shortest_path_tb;
  import apsp_pkg::*;

  localparam int NODES = 64;
  localparam int QUIET_LIMIT = 1000000;
  localparam logic [DIST_W-1:0] DIST_TOP = '1;

  class route_checker;
    bit [6:0]          node_count;
    bit                link_on   [NODES][NODES];
    bit [COST_W-1:0]   link_cost [NODES][NODES];
    bit                dist_ok   [NODES][NODES];
    bit [DIST_W-1:0]   dist_len  [NODES][NODES];
    bit                hop_ok    [NODES][NODES];
    bit [NODE_W-1:0]   hop_node  [NODES][NODES];
    out_word_t         pending_reads[$];
    int                errors;

    function new();
      node_count = NODE_COUNT_RESET;
      errors = 0;
      foreach (link_on[i, j]) begin
        link_on[i][j] = 1'b0;
        link_cost[i][j] = '0;
        dist_ok[i][j] = 1'b0;
        dist_len[i][j] = '0;
        hop_ok[i][j] = 1'b0;
        hop_node[i][j] = '0;
      end
    endfunction

    function void set_node_count(bit [6:0] v);
      node_count = v;
    endfunction

    function int pending();
      return pending_reads.size();
    endfunction

    function void take_word(in_word_t w);
      int n;
      logic [DIST_W-1:0] dik;
      logic [DIST_W:0] sum;
      out_word_t exp_word;
      case (w.operation)
        OP_CLEAR: begin
          foreach (link_on[i, j]) link_on[i][j] = 1'b0;
        end
        OP_LOAD: begin
          if (w.src_node != w.dst_node) begin
            link_on[w.src_node][w.dst_node] = w.link_present;
            link_on[w.dst_node][w.src_node] = w.link_present;
            link_cost[w.src_node][w.dst_node] = w.link_present ? w.link_distance : '0;
            link_cost[w.dst_node][w.src_node] = w.link_present ? w.link_distance : '0;
          end
        end
        OP_COMPUTE: begin
          n = (node_count > NODES) ? NODES : node_count;
          foreach (dist_ok[i, j]) begin
            dist_ok[i][j] = 1'b0;
            dist_len[i][j] = '0;
            hop_ok[i][j] = 1'b0;
            hop_node[i][j] = '0;
          end
          for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
              if (i == j) begin
                dist_ok[i][j] = 1'b1;
              end else if (link_on[i][j]) begin
                dist_ok[i][j] = 1'b1;
                dist_len[i][j] = DIST_W'(link_cost[i][j]);
                hop_ok[i][j] = 1'b1;
                hop_node[i][j] = i[NODE_W-1:0];
              end
            end
          end
          for (int k = 0; k < n; k++) begin
            for (int i = 0; i < n; i++) begin
              if (!dist_ok[i][k]) continue;
              dik = dist_len[i][k];
              for (int j = 0; j < n; j++) begin
                if (!dist_ok[k][j]) continue;
                sum = {1'b0, dik} + {1'b0, dist_len[k][j]};
                if (sum > {1'b0, DIST_TOP}) sum = {1'b0, DIST_TOP};
                if (!dist_ok[i][j] || dist_len[i][j] > sum[DIST_W-1:0]) begin
                  dist_ok[i][j] = 1'b1;
                  dist_len[i][j] = sum[DIST_W-1:0];
                  hop_ok[i][j] = 1'b1;
                  hop_node[i][j] = k[NODE_W-1:0];
                end
              end
            end
          end
        end
        default: begin
          exp_word = '0;
          if (dist_ok[w.src_node][w.dst_node]) begin
            exp_word.path_distance = dist_len[w.src_node][w.dst_node];
            exp_word.reachable = 1'b1;
          end
          if (hop_ok[w.src_node][w.dst_node]) begin
            exp_word.via_valid = 1'b1;
            exp_word.via_node = hop_node[w.src_node][w.dst_node];
          end
          pending_reads.push_back(exp_word);
        end
      endcase
    endfunction

    function void match_result(out_word_t got);
      out_word_t want;
      if (pending_reads.size() == 0) begin
        $error("unexpected result word: %h", got);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      if (got.path_distance !== want.path_distance) begin
        $error("path_distance: expected %0d, got %0d", want.path_distance, got.path_distance);
        errors++;
      end
      if (got.reachable !== want.reachable) begin
        $error("reachable: expected %0d, got %0d", want.reachable, got.reachable);
        errors++;
      end
      if (got.via_valid !== want.via_valid) begin
        $error("via_valid: expected %0d, got %0d", want.via_valid, got.via_valid);
        errors++;
      end
      if (got.via_node !== want.via_node) begin
        $error("via_node: expected %0d, got %0d", want.via_node, got.via_node);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  route_checker chk = new();
  bit gaps_on = 1'b1;
  int stall_left = 0;

  all_pairs_shortest_path #(
    .MAX_NODES(NODES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channels are sampled here on pre-edge values, so this sees exactly
  // what the block saw at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      chk.match_result(out_word);
    end
    if (rst_n && in_valid && !in_stall) begin
      chk.take_word(in_word);
    end
  end

  // Result side: after each accepted word, hold off for a random number of cycles when gaps are on.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      stall_left = gaps_on ? $urandom_range(0, 4) : 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic in_word_t word_of(op_t op, int src, int dst, int cost, bit present);
    in_word_t w;
    w.operation = op;
    w.src_node = src[NODE_W-1:0];
    w.dst_node = dst[NODE_W-1:0];
    w.link_distance = cost[COST_W-1:0];
    w.link_present = present;
    return w;
  endfunction

  function automatic int pick_node(int span);
    if ($urandom_range(0, 7) == 0 || span > NODES) return $urandom_range(0, NODES - 1);
    return $urandom_range(0, span - 1);
  endfunction

  function automatic int pick_cost();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return $urandom_range(0, 255);
      2: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic send(in_word_t w);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Every phase ends on a read, so once its result is back the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(int v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chk.set_node_count(v[CFG_W-1:0]);
  endtask

  task automatic run_phase(int count);
    int n;
    int span;
    in_word_t w;
    write_count(count);
    gaps_on = ($urandom_range(0, 3) != 0);
    n = (count > NODES) ? NODES : count;
    span = (n < 2) ? 4 : n + 1;
    if ($urandom_range(0, 3) == 0) begin
      send(word_of(OP_CLEAR, $urandom, $urandom, $urandom, 1'($urandom)));
    end
    repeat ($urandom_range(3, 7)) begin
      send(word_of(OP_LOAD, pick_node(span), pick_node(span), pick_cost(),
                   $urandom_range(0, 7) != 0));
    end
    if ($urandom_range(0, 2) == 0) begin
      w = word_of(op_t'(2'($urandom_range(0, 3))), $urandom, $urandom, $urandom,
                  1'($urandom));
      // A full-size compute is slow; keep noise cheap.
      if (w.operation == OP_COMPUTE && n > 16) w.operation = OP_READ;
      send(w);
    end
    send(word_of(OP_COMPUTE, $urandom, $urandom, $urandom, 1'($urandom)));
    repeat ($urandom_range(3, 6)) begin
      send(word_of(OP_READ, pick_node(span), pick_node(span), $urandom, 1'($urandom)));
    end
    send(word_of(OP_READ, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                 $urandom, 1'($urandom)));
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset node count of 64.
    send(word_of(OP_READ, 0, 63, 0, 1'b0));
    send(word_of(OP_LOAD, 0, 1, 0, 1'b1));
    send(word_of(OP_LOAD, 1, 63, 65535, 1'b1));
    send(word_of(OP_LOAD, 5, 5, 77, 1'b1));
    send(word_of(OP_LOAD, 2, 3, 100, 1'b1));
    send(word_of(OP_LOAD, 3, 2, 0, 1'b0));
    send(word_of(OP_LOAD, 62, 63, 12345, 1'b1));
    send(word_of(OP_COMPUTE, 63, 63, 65535, 1'b1));
    send(word_of(OP_READ, 0, 63, 0, 1'b0));
    send(word_of(OP_READ, 63, 0, 65535, 1'b1));
    send(word_of(OP_READ, 0, 0, 0, 1'b0));
    send(word_of(OP_READ, 2, 3, 0, 1'b0));
    send(word_of(OP_READ, 62, 0, 0, 1'b0));
    send(word_of(OP_READ, 63, 63, 0, 1'b0));
    send(word_of(OP_READ, 42, 21, 0, 1'b0));
    // Clearing links leaves the computed tables as they were.
    send(word_of(OP_CLEAR, 0, 0, 0, 1'b0));
    send(word_of(OP_READ, 0, 1, 0, 1'b0));
    drain();

    // Node count extremes first: one node, none, above the maximum, two.
    run_phase(1);
    run_phase(0);
    run_phase(127);
    run_phase(2);
    repeat (4) run_phase($urandom_range(3, 12));

    repeat (16) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/apsp_pkg.sv
hdl/apsp_ram.sv
hdl/apsp_ctrl.sv
hdl/apsp_dp.sv
hdl/all_pairs_shortest_path.sv
dv/all_pairs_shortest_path_tb.sv
